### rtl/core/rrof_pkg.sv
// ----------------------------------------------------------------------------
// rrof_pkg
// shared constants and types of the rgb rank order filter
// ----------------------------------------------------------------------------
package rrof_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ROW_SLOTS = 7;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int SLOT_W    = $clog2(ROW_SLOTS);
  localparam int ADDR_W    = SLOT_W + COL_W;
  localparam int MEM_DEPTH = ROW_SLOTS * MAX_WIDTH;
  localparam int PIX_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int RANK_W    = 6;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANK   = 2'd3;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // controls from the sequencer to the rank selector
  typedef struct packed {
    logic start;
    logic sample_vld;
    logic last;
  } sel_ctrl_t;

endpackage

### rtl/core/rrof_if.sv
// ----------------------------------------------------------------------------
// rrof channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface rrof_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface rrof_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

### rtl/core/rrof_line_mem.sv
// ----------------------------------------------------------------------------
// rrof_line_mem
// line store ring: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module rrof_line_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [rrof_pkg::ADDR_W-1:0] wr_addr,
  input  logic [rrof_pkg::PIX_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [rrof_pkg::ADDR_W-1:0] rd_addr,
  output logic [rrof_pkg::PIX_W-1:0]  rd_data_r
);

  logic [rrof_pkg::PIX_W-1:0] mem [0:rrof_pkg::MEM_DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/rrof_rank_sel.sv
// ----------------------------------------------------------------------------
// rrof_rank_sel
// radix select: one bit of each channel's answer per pass over the window
// ----------------------------------------------------------------------------
module rrof_rank_sel (
  input  logic                        clk,
  input  rrof_pkg::sel_ctrl_t         ctrl,
  input  logic [rrof_pkg::RANK_W-1:0] rank_init,
  input  logic [rrof_pkg::PIX_W-1:0]  sample,
  output logic [rrof_pkg::PIX_W-1:0]  result
);

  logic [rrof_pkg::CHAN_W-1:0] prefix_r [3];
  logic [rrof_pkg::CHAN_W-1:0] prefix_nxt [3];
  logic [rrof_pkg::RANK_W-1:0] rem_r [3];
  logic [rrof_pkg::RANK_W-1:0] rem_nxt [3];
  logic [rrof_pkg::RANK_W-1:0] cnt_r [3];
  logic [rrof_pkg::RANK_W-1:0] cnt_nxt [3];
  logic [rrof_pkg::CHAN_W-1:0] mask_r, mask_nxt;
  logic [rrof_pkg::CHAN_W-1:0] bit_r, bit_nxt;

  // per channel count of matching samples with a zero in the current bit
  always_comb begin
    logic [rrof_pkg::CHAN_W-1:0] v;
    logic [rrof_pkg::RANK_W-1:0] tot;
    logic                        inc;
    mask_nxt = mask_r;
    bit_nxt  = bit_r;
    for (int c = 0; c < 3; c++) begin
      prefix_nxt[c] = prefix_r[c];
      rem_nxt[c]    = rem_r[c];
      cnt_nxt[c]    = cnt_r[c];
      v   = sample[rrof_pkg::PIX_W-1-rrof_pkg::CHAN_W*c -: rrof_pkg::CHAN_W];
      inc = (((v ^ prefix_r[c]) & mask_r) == '0) && ((v & bit_r) == '0);
      tot = cnt_r[c] + {{(rrof_pkg::RANK_W-1){1'b0}}, inc};
      if (ctrl.start) begin
        prefix_nxt[c] = '0;
        rem_nxt[c]    = rank_init;
        cnt_nxt[c]    = '0;
      end else if (ctrl.sample_vld) begin
        if (ctrl.last) begin
          cnt_nxt[c] = '0;
          if (rem_r[c] >= tot) begin
            prefix_nxt[c] = prefix_r[c] | bit_r;
            rem_nxt[c]    = rem_r[c] - tot;
          end
        end else begin
          cnt_nxt[c] = tot;
        end
      end
    end
    if (ctrl.start) begin
      mask_nxt = '0;
      bit_nxt  = {1'b1, {(rrof_pkg::CHAN_W-1){1'b0}}};
    end else if (ctrl.sample_vld && ctrl.last) begin
      mask_nxt = mask_r | bit_r;
      bit_nxt  = bit_r >> 1;
    end
  end

  // select state
  always_ff @(posedge clk) begin
    prefix_r <= prefix_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    mask_r   <= mask_nxt;
    bit_r    <= bit_nxt;
  end

  assign result = {prefix_r[0], prefix_r[1], prefix_r[2]};

endmodule

### rtl/core/rgb_rank_order_filter.sv
// ----------------------------------------------------------------------------
// rgb_rank_order_filter
// rank order filter over a raster rgb pixel stream with a ring of line stores
// ----------------------------------------------------------------------------
// Pixels (kind 0) enter on in_ch in raster order and are written to a ring of
// seven line stores. Once the input at the clamped lower right corner of the
// next output window has arrived, the block emits that output pixel on out_ch:
// per channel the value at the configured rank of the sorted window. After the
// last pixel, drain items (kind 1) emit the remaining outputs one each; a pixel
// that arrives while an output is ready is dropped. frame_end marks the last
// output of a frame, after which a new frame starts.
// One item is taken at a time. After S_CHECK an item with no output to follow
// is done; otherwise eight passes of single-port reads of the line store scan
// the window, one bit of the answer per pass, and S_FLUSH and S_EMIT follow. A
// finished result waits in the output register while the next item is accepted;
// a stalled receiver only holds up the next emission. Reset restores the default
// registers and starts a frame; the line store is not cleared. Any register
// write restarts the frame.
// ----------------------------------------------------------------------------
module rgb_rank_order_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  rrof_in_if.sink                        in_ch,
  rrof_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rrof_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrof_pkg::CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_FLUSH, S_EMIT} state_t;

  localparam int CW = rrof_pkg::COL_W;
  localparam int RW = rrof_pkg::ROW_W;
  localparam int SW = rrof_pkg::SLOT_W;

  state_t             state_r, state_nxt;
  logic [11:0]        width_r, width_nxt;
  logic [12:0]        height_r, height_nxt;
  logic [2:0]         window_r, window_nxt;
  logic [5:0]         rank_r, rank_nxt;
  logic [CW-1:0]      in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0]      in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SW-1:0]      in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic               frame_rcvd_r, frame_rcvd_nxt;
  logic signed [2:0]  di_r, di_nxt, dj_r, dj_nxt;
  logic [2:0]         pass_r, pass_nxt;
  logic               samp_vld_r, last_r;
  logic               out_valid_r, out_valid_nxt;
  logic [rrof_pkg::PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic               out_end_r, out_end_nxt;

  logic [CW-1:0]      wm1;
  logic [RW-1:0]      hm1;
  logic [1:0]         half;
  logic signed [2:0]  p_s;
  logic [RW:0]        ry;
  logic [CW:0]        rx;
  logic               out_rdy;
  logic [5:0]         nm1, rank_sat;
  logic               in_fire, store, scan_last, start;
  logic               rd_en;
  logic [rrof_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [rrof_pkg::PIX_W-1:0]  rd_data, sel_result;
  logic signed [RW+1:0] ny_s, rel_s;
  logic signed [CW+1:0] nx_s;
  logic [RW-1:0]      ny;
  logic [CW-1:0]      nx;
  logic signed [4:0]  slot_s;
  logic [SW-1:0]      rd_slot;
  rrof_pkg::sel_ctrl_t sel_ctrl;

  // effective frame geometry, window and saturated rank
  always_comb begin
    if (width_r == '0) wm1 = '0;
    else if (width_r > 12'(rrof_pkg::MAX_WIDTH)) wm1 = CW'(rrof_pkg::MAX_WIDTH - 1);
    else wm1 = CW'(width_r - 12'd1);
    if (height_r == '0) hm1 = '0;
    else if (height_r > 13'd4096) hm1 = '1;
    else hm1 = RW'(height_r - 13'd1);
    half = (window_r[2:1] == 2'd0) ? 2'd1 : window_r[2:1];
    p_s  = signed'({1'b0, half});
    case (half)
      2'd1:    nm1 = 6'd8;
      2'd2:    nm1 = 6'd24;
      default: nm1 = 6'd48;
    endcase
    rank_sat = (rank_r > nm1) ? nm1 : rank_r;
  end

  // next output ready once its lower right window corner is in
  always_comb begin
    ry = {1'b0, out_row_r} + {{(RW-1){1'b0}}, half};
    if (ry > {1'b0, hm1}) ry = {1'b0, hm1};
    rx = {1'b0, out_col_r} + {{(CW-1){1'b0}}, half};
    if (rx > {1'b0, wm1}) rx = {1'b0, wm1};
    out_rdy = frame_rcvd_r || ({1'b0, in_row_r} > ry)
              || (({1'b0, in_row_r} == ry) && ({1'b0, in_col_r} > rx));
  end

  // window read address with clamped coordinates
  always_comb begin
    ny_s = signed'({2'b00, out_row_r}) + (RW+2)'(di_r);
    if (ny_s < 0) ny = '0;
    else if (ny_s > signed'({2'b00, hm1})) ny = hm1;
    else ny = ny_s[RW-1:0];
    rel_s  = signed'({2'b00, ny}) - signed'({2'b00, out_row_r});
    slot_s = signed'({2'b00, out_slot_r}) + rel_s[4:0];
    if (slot_s < 0) slot_s = slot_s + 5'sd7;
    else if (slot_s >= 5'sd7) slot_s = slot_s - 5'sd7;
    rd_slot = slot_s[SW-1:0];
    nx_s = signed'({2'b00, out_col_r}) + (CW+2)'(dj_r);
    if (nx_s < 0) nx = '0;
    else if (nx_s > signed'({2'b00, wm1})) nx = wm1;
    else nx = nx_s[CW-1:0];
    rd_addr = {rd_slot, nx};
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign store     = in_fire && (in_ch.kind == rrof_pkg::KIND_PIXEL) && !out_rdy;
  assign wr_addr   = {in_slot_r, in_col_r};
  assign rd_en     = (state_r == S_SCAN);
  assign scan_last = (di_r == p_s) && (dj_r == p_s);
  assign start     = (state_r == S_CHECK) && out_rdy;

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    window_nxt     = window_r;
    rank_nxt       = rank_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    in_slot_nxt    = in_slot_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_slot_nxt   = out_slot_r;
    frame_rcvd_nxt = frame_rcvd_r;
    di_nxt         = di_r;
    dj_nxt         = dj_r;
    pass_nxt       = pass_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_pix_nxt    = out_pix_r;
    out_end_nxt    = out_end_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == rrof_pkg::KIND_DRAIN) begin
            state_nxt = S_CHECK;
          end else if (store) begin
            state_nxt = S_CHECK;
            if (in_col_r == wm1) begin
              in_col_nxt = '0;
              if (in_row_r >= hm1) begin
                frame_rcvd_nxt = 1'b1;
              end else begin
                in_row_nxt  = in_row_r + 1'b1;
                in_slot_nxt = (in_slot_r == SW'(rrof_pkg::ROW_SLOTS - 1)) ? '0
                              : in_slot_r + 1'b1;
              end
            end else begin
              in_col_nxt = in_col_r + 1'b1;
            end
          end
        end
      end
      S_CHECK: begin
        di_nxt   = -p_s;
        dj_nxt   = -p_s;
        pass_nxt = '0;
        state_nxt = out_rdy ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (dj_r == p_s) begin
          dj_nxt = -p_s;
          if (di_r == p_s) begin
            di_nxt   = -p_s;
            pass_nxt = pass_r + 1'b1;
            if (pass_r == 3'd7) state_nxt = S_FLUSH;
          end else begin
            di_nxt = di_r + 3'sd1;
          end
        end else begin
          dj_nxt = dj_r + 3'sd1;
        end
      end
      S_FLUSH: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_pix_nxt   = sel_result;
          out_end_nxt   = 1'b0;
          if (out_col_r == wm1) begin
            out_col_nxt = '0;
            if (out_row_r >= hm1) begin
              out_end_nxt    = 1'b1;
              in_col_nxt     = '0;
              in_row_nxt     = '0;
              in_slot_nxt    = '0;
              out_row_nxt    = '0;
              out_slot_nxt   = '0;
              frame_rcvd_nxt = 1'b0;
            end else begin
              out_row_nxt  = out_row_r + 1'b1;
              out_slot_nxt = (out_slot_r == SW'(rrof_pkg::ROW_SLOTS - 1)) ? '0
                             : out_slot_r + 1'b1;
            end
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register writes restart the frame
    if (cfg_we) begin
      unique case (cfg_index)
        rrof_pkg::REG_WIDTH:  width_nxt  = cfg_wdata[11:0];
        rrof_pkg::REG_HEIGHT: height_nxt = cfg_wdata;
        rrof_pkg::REG_WINDOW: window_nxt = cfg_wdata[2:0];
        rrof_pkg::REG_RANK:   rank_nxt   = cfg_wdata[5:0];
        default: ;
      endcase
      in_col_nxt     = '0;
      in_row_nxt     = '0;
      in_slot_nxt    = '0;
      out_col_nxt    = '0;
      out_row_nxt    = '0;
      out_slot_nxt   = '0;
      frame_rcvd_nxt = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      width_r      <= 12'd2048;
      height_r     <= 13'd1024;
      window_r     <= 3'd3;
      rank_r       <= 6'd4;
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_slot_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_slot_r   <= '0;
      frame_rcvd_r <= 1'b0;
      samp_vld_r   <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      window_r     <= window_nxt;
      rank_r       <= rank_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      in_slot_r    <= in_slot_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      out_slot_r   <= out_slot_nxt;
      frame_rcvd_r <= frame_rcvd_nxt;
      samp_vld_r   <= rd_en;
      last_r       <= rd_en && scan_last;
      out_valid_r  <= out_valid_nxt;
    end
    di_r      <= di_nxt;
    dj_r      <= dj_nxt;
    pass_r    <= pass_nxt;
    out_pix_r <= out_pix_nxt;
    out_end_r <= out_end_nxt;
  end

  assign sel_ctrl = '{start: start, sample_vld: samp_vld_r, last: last_r};

  rrof_line_mem u_mem (
    .clk       (clk),
    .wr_en     (store),
    .wr_addr   (wr_addr),
    .wr_data   ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  rrof_rank_sel u_sel (
    .clk       (clk),
    .ctrl      (sel_ctrl),
    .rank_init (rank_sat),
    .sample    (rd_data),
    .result    (sel_result)
  );

  // channel ports
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_pix_r[23:16];
  assign out_ch.green_out = out_pix_r[15:8];
  assign out_ch.blue_out  = out_pix_r[7:0];
  assign out_ch.frame_end = out_end_r;

endmodule
